FILE: rtl/vital_sign_frame_receiver_core_assert.svh
// Assertion macros used by the receiver controller.
`ifndef VITAL_SIGN_FRAME_RECEIVER_CORE_ASSERT_SVH
`define VITAL_SIGN_FRAME_RECEIVER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define VSFR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define VSFR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/vsfr_pkg.sv
`timescale 1ns / 1ps
package vsfr_pkg;

  localparam logic [7:0] CRC_POLY      = 8'h31;
  localparam logic [7:0] CRC_INIT      = 8'h00;
  localparam logic [7:0] HDR_FIRST_RST = 8'hAA;
  localparam logic [7:0] HDR_SECOND_RST = 8'h55;
  localparam logic [7:0] FLAG_RST      = 8'h00;
  localparam int unsigned FRAME_BYTES  = 16;

  // Frame status codes
  localparam logic [1:0] FS_GOOD = 2'd0;
  localparam logic [1:0] FS_FLAG = 2'd1;
  localparam logic [1:0] FS_CRC  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_HDR_FIRST  = 2'd0;
  localparam logic [1:0] REG_HDR_SECOND = 2'd1;
  localparam logic [1:0] REG_FLAG       = 2'd2;

  typedef enum logic [2:0] {
    ST_HUNT, ST_HDR2, ST_BODY, ST_CONV, ST_SUM, ST_DINIT, ST_DIV, ST_EMIT
  } state_t;

  typedef struct packed {
    logic load_first;
    logic load_second;
    logic load_body;
    logic win_push;
    logic sum_step;
    logic div_init;
    logic div_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic is_first;
    logic is_second;
    logic frame_end;
    logic frame_good;
    logic sum_done;
    logic div_done;
    logic out_busy;
  } sts_t;

  // CRC-8, MSB first, one byte
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  // binary32 to unsigned Q8.8, truncating, clamped
  function automatic logic [15:0] to_q88(input logic [31:0] bits);
    logic [7:0]  ex;
    logic [22:0] man;
    logic [7:0]  rs;
    logic [23:0] sh;
    ex  = bits[30:23];
    man = bits[22:0];
    rs  = 8'd142 - ex;
    sh  = {1'b1, man} >> rs[4:0];
    if (ex == 8'hFF) begin
      return (man != '0 || bits[31]) ? 16'h0000 : 16'hFFFF;
    end
    if (bits[31] || ex == 8'h00) return 16'h0000;
    if (ex >= 8'd135) return 16'hFFFF;
    if (rs >= 8'd24) return 16'h0000;
    return sh[15:0];
  endfunction

endpackage

FILE: rtl/vsfr_ctrl.sv
`timescale 1ns / 1ps
`include "vital_sign_frame_receiver_core_assert.svh"
module vsfr_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  vsfr_pkg::sts_t sts,
  output vsfr_pkg::cmd_t cmd
);
  import vsfr_pkg::*;

  state_t state_r, state_nxt;
  logic   acc;

  // hold state
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_HUNT;
    else        state_r <= state_nxt;
  end

  assign acc = in_valid && !in_stall;

  // sequence the frame hunt and the end-of-frame work
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_HUNT: begin
        in_stall = 1'b0;
        if (acc && sts.is_first) begin
          cmd.load_first = 1'b1;
          state_nxt      = ST_HDR2;
        end
      end
      ST_HDR2: begin
        in_stall = 1'b0;
        if (acc) begin
          if (sts.is_second) begin
            cmd.load_second = 1'b1;
            state_nxt       = ST_BODY;
          end else if (sts.is_first) begin
            cmd.load_first = 1'b1;
          end else begin
            state_nxt = ST_HUNT;
          end
        end
      end
      ST_BODY: begin
        in_stall = 1'b0;
        if (acc) begin
          cmd.load_body = 1'b1;
          if (sts.frame_end) state_nxt = sts.frame_good ? ST_CONV : ST_EMIT;
        end
      end
      ST_CONV: begin
        cmd.win_push = 1'b1;
        state_nxt    = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum_step = 1'b1;
        if (sts.sum_done) state_nxt = ST_DINIT;
      end
      ST_DINIT: begin
        cmd.div_init = 1'b1;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!sts.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_HUNT;
        end
      end
      default: state_nxt = ST_HUNT;
    endcase
  end

  `VSFR_ASSERT_IMP(a_emit_free, cmd.emit, !sts.out_busy, "emit while result pending")
  `VSFR_ASSERT_NXT(a_good_conv, state_r == ST_BODY && acc && sts.frame_end && sts.frame_good, state_r == ST_CONV, "good frame skipped conversion")
  `VSFR_ASSERT_IMP(a_busy_stall, state_r == ST_SUM || state_r == ST_DIV, in_stall, "byte taken during averaging")

endmodule

FILE: rtl/vsfr_dp.sv
`timescale 1ns / 1ps
module vsfr_dp #(
  parameter int WINDOW_DEPTH = 5
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_valid,
  input  logic [1:0]     cfg_index,
  input  logic [7:0]     cfg_wdata,
  input  logic [7:0]     in_rx_byte,
  input  vsfr_pkg::cmd_t cmd,
  output vsfr_pkg::sts_t sts,
  input  logic           out_stall,
  output logic           out_valid,
  output logic [1:0]     out_frame_status,
  output logic [31:0]    out_frame_counter,
  output logic [15:0]    out_breath_average,
  output logic [15:0]    out_heart_average,
  output logic           out_data_valid
);
  import vsfr_pkg::*;

  localparam int CW   = $clog2(WINDOW_DEPTH + 1);
  localparam int SW   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int SUMW = 16 + CW;
  localparam int CNTW = $clog2(SUMW);

  logic [7:0]  hdr_first_r, hdr_second_r, flag_r;
  logic [3:0]  pos_r;
  logic [7:0]  crc_r, byte2_r;
  logic [95:0] body_r;
  logic [1:0]  fstat_r;
  logic [15:0] win_b_r [WINDOW_DEPTH];
  logic [15:0] win_h_r [WINDOW_DEPTH];
  logic [SW-1:0] slot_r;
  logic [CW-1:0] fill_r;
  logic [CNTW-1:0] cnt_r;
  logic [SUMW-1:0] sum_b_r, sum_h_r, q_b_r, q_h_r;
  logic [CW:0]     rem_b_r, rem_h_r;
  logic [15:0] mean_b_r, mean_h_r;
  logic        out_valid_r;
  logic [1:0]  out_status_r;
  logic [31:0] out_counter_r;
  logic [15:0] out_b_r, out_h_r;
  logic        out_dvalid_r;
  logic [CW:0] sh_b, sh_h, dvs;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_first_r  <= HDR_FIRST_RST;
      hdr_second_r <= HDR_SECOND_RST;
      flag_r       <= FLAG_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_HDR_FIRST:  hdr_first_r  <= cfg_wdata;
        REG_HDR_SECOND: hdr_second_r <= cfg_wdata;
        REG_FLAG:       flag_r       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // status back to the controller
  assign sts.is_first   = (in_rx_byte == hdr_first_r);
  assign sts.is_second  = (in_rx_byte == hdr_second_r);
  assign sts.frame_end  = (pos_r == 4'(FRAME_BYTES - 1));
  assign sts.frame_good = (byte2_r == flag_r) && (crc_r == in_rx_byte);
  assign sts.sum_done   = (cnt_r == CNTW'(WINDOW_DEPTH - 1));
  assign sts.div_done   = (cnt_r == CNTW'(SUMW - 1));
  assign sts.out_busy   = out_valid_r;

  // capture the frame: running CRC, flag byte, payload bytes
  always_ff @(posedge clk) begin
    if (cmd.load_first) begin
      pos_r <= 4'd1;
      crc_r <= crc8_byte(CRC_INIT, in_rx_byte);
    end else if (cmd.load_second) begin
      pos_r <= 4'd2;
      crc_r <= crc8_byte(crc_r, in_rx_byte);
    end else if (cmd.load_body) begin
      pos_r <= pos_r + 4'd1;
      if (pos_r != 4'(FRAME_BYTES - 1)) crc_r <= crc8_byte(crc_r, in_rx_byte);
      if (pos_r == 4'd2) byte2_r <= in_rx_byte;
      if (pos_r >= 4'd3 && pos_r != 4'(FRAME_BYTES - 1))
        body_r <= {in_rx_byte, body_r[95:8]};
      if (pos_r == 4'(FRAME_BYTES - 1)) begin
        if (byte2_r != flag_r)         fstat_r <= FS_FLAG;
        else if (crc_r != in_rx_byte)  fstat_r <= FS_CRC;
        else                           fstat_r <= FS_GOOD;
      end
    end
  end

  // rate window: push converted rates, advance slot and fill
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        win_b_r[i] <= '0;
        win_h_r[i] <= '0;
      end
      slot_r <= '0;
      fill_r <= '0;
    end else if (cmd.win_push) begin
      win_b_r[slot_r] <= to_q88(body_r[63:32]);
      win_h_r[slot_r] <= to_q88(body_r[95:64]);
      slot_r <= (slot_r == SW'(WINDOW_DEPTH - 1)) ? '0 : slot_r + SW'(1);
      if (fill_r < CW'(WINDOW_DEPTH)) fill_r <= fill_r + CW'(1);
    end
  end

  // restoring divide, one quotient bit per cycle
  assign dvs  = {1'b0, fill_r};
  assign sh_b = {rem_b_r[CW-1:0], q_b_r[SUMW-1]};
  assign sh_h = {rem_h_r[CW-1:0], q_h_r[SUMW-1]};

  // accumulate the window, then divide by the fill
  always_ff @(posedge clk) begin
    if (cmd.win_push) begin
      cnt_r   <= '0;
      sum_b_r <= '0;
      sum_h_r <= '0;
    end else if (cmd.sum_step) begin
      cnt_r   <= cnt_r + CNTW'(1);
      sum_b_r <= sum_b_r + SUMW'(win_b_r[cnt_r[SW-1:0]]);
      sum_h_r <= sum_h_r + SUMW'(win_h_r[cnt_r[SW-1:0]]);
    end else if (cmd.div_init) begin
      cnt_r   <= '0;
      q_b_r   <= sum_b_r;
      q_h_r   <= sum_h_r;
      rem_b_r <= '0;
      rem_h_r <= '0;
    end else if (cmd.div_step) begin
      cnt_r <= cnt_r + CNTW'(1);
      if (sh_b >= dvs) begin
        rem_b_r <= sh_b - dvs;
        q_b_r   <= {q_b_r[SUMW-2:0], 1'b1};
      end else begin
        rem_b_r <= sh_b;
        q_b_r   <= {q_b_r[SUMW-2:0], 1'b0};
      end
      if (sh_h >= dvs) begin
        rem_h_r <= sh_h - dvs;
        q_h_r   <= {q_h_r[SUMW-2:0], 1'b1};
      end else begin
        rem_h_r <= sh_h;
        q_h_r   <= {q_h_r[SUMW-2:0], 1'b0};
      end
    end
  end

  // hold the latest means for frames that leave the window alone
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_b_r <= '0;
      mean_h_r <= '0;
    end else if (cmd.emit && fstat_r == FS_GOOD) begin
      mean_b_r <= q_b_r[15:0];
      mean_h_r <= q_h_r[15:0];
    end
  end

  // output register: load on emit, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r <= fstat_r;
      out_dvalid_r <= (fill_r != '0);
      if (fstat_r == FS_GOOD) begin
        out_counter_r <= body_r[31:0];
        out_b_r       <= q_b_r[15:0];
        out_h_r       <= q_h_r[15:0];
      end else begin
        out_counter_r <= '0;
        out_b_r       <= mean_b_r;
        out_h_r       <= mean_h_r;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_frame_status   = out_status_r;
  assign out_frame_counter  = out_counter_r;
  assign out_breath_average = out_b_r;
  assign out_heart_average  = out_h_r;
  assign out_data_valid     = out_dvalid_r;

endmodule

FILE: rtl/vital_sign_frame_receiver_core.sv
`timescale 1ns / 1ps
// Serial frame receiver: takes one received byte per item, hunts for the two
// header bytes, collects a 16-byte frame and gives one result per completed
// frame (status, counter, windowed Q8.8 breath and heart means, valid flag).
// Header and body bytes are taken one per cycle; CRC-8 is updated as each byte
// before the CRC byte arrives. After a good frame the block converts the two
// rates, sums the window and divides bit-serially, holding input through these
// steps and the emit step after the last byte; after a bad frame it holds input
// only in the emit step. Either adds any wait for a pending result.
// A finished result sits in an output register, so the next frame's bytes are
// taken while it waits.
// Configuration writes are taken every cycle (cfg_ready is tied high).
module vital_sign_frame_receiver_core #(
  parameter int WINDOW_DEPTH = 5
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_frame_status,
  output logic [31:0] out_frame_counter,
  output logic [15:0] out_breath_average,
  output logic [15:0] out_heart_average,
  output logic        out_data_valid
);
  import vsfr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  vsfr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  vsfr_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_rx_byte         (in_rx_byte),
    .cmd                (cmd),
    .sts                (sts),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_frame_status   (out_frame_status),
    .out_frame_counter  (out_frame_counter),
    .out_breath_average (out_breath_average),
    .out_heart_average  (out_heart_average),
    .out_data_valid     (out_data_valid)
  );

endmodule
